/* rtl/olad_pkg.sv */
// Package for the ordered list block: command and status codes, and the
// command and status structs exchanged by the controller and the datapath.
// No dependencies.
`default_nettype none

package olad_pkg;

  // Operation codes carried by the input transaction.
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Status codes carried by the result transaction.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Read address selection for the entry memory.
  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_IDX  = 2'd1;
  localparam logic [1:0] RD_IDX1 = 2'd2;
  localparam logic [1:0] RD_IDX2 = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       val_load;
    logic       idx_clr;
    logic       idx_inc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       we_append;
    logic       we_shift;
    logic [1:0] rd_sel;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_elem;
    logic       out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic at_end;
    logic shift_end;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/ordered_list_append_delete.sv */
// Ordered list of signed 32-bit values with append, first-match delete and read-out.
// Append, error and unused commands give their result through the result state and the
// result register; delete with n entries held runs n scan and compaction steps, one entry
// per cycle, then gives its result; read-out gives one entry per cycle while the result
// register is free. One transaction is in work at a time; the memory port sets the pace.
// Reset empties the list; entry memory contents are not cleared.
`default_nettype none

module ordered_list_append_delete
  import olad_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_element,
  output logic [1:0]              out_status,
  output logic [4:0]              out_count,
  output logic                    out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  olad_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd  (in_cmd),
    .stat    (stat),
    .cmd     (cmd)
  );

  olad_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_value   (in_value),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_element(out_element),
    .out_status (out_status),
    .out_count  (out_count),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

/* rtl/olad_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`default_nettype none

module olad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* rtl/olad_dp.sv */
// Datapath of the ordered list: entry memory, fill count, scan index,
// search value and the result register.
// Depends on olad_pkg and olad_ram.
`default_nettype none

module olad_dp
  import olad_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic signed [31:0] in_value,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic signed [31:0]      out_element,
  output logic [1:0]              out_status,
  output logic [4:0]              out_count,
  output logic                    out_last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [31:0]       value_r;
  logic [31:0]       rd_data;
  logic [IW-1:0]     raddr;
  logic              ram_we;
  logic [IW-1:0]     waddr;
  logic [31:0]       wdata;
  logic [CW-1:0]     idx_ext;
  logic              out_valid_r;
  logic [31:0]       out_element_r;
  logic [1:0]        out_status_r;
  logic [4:0]        out_count_r;
  logic              out_last_r;

  assign idx_ext = CW'(idx_r);

  // Status toward the controller.
  always_comb begin
    stat.full      = (count_r == CW'(CAPACITY));
    stat.empty     = (count_r == '0);
    stat.match     = (rd_data == value_r);
    stat.at_end    = ((idx_ext + CW'(1)) == count_r);
    stat.shift_end = ((idx_ext + CW'(2)) == count_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  // Memory address and write data selection.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO: raddr = '0;
      RD_IDX:  raddr = idx_r;
      RD_IDX1: raddr = IW'(idx_ext + CW'(1));
      RD_IDX2: raddr = IW'(idx_ext + CW'(2));
      default: raddr = '0;
    endcase
    ram_we = cmd.we_append || cmd.we_shift;
    if (cmd.we_append) begin
      waddr = IW'(count_r);
      wdata = in_value;
    end else begin
      waddr = idx_r;
      wdata = rd_data;
    end
  end

  olad_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata_r(rd_data)
  );

  // Fill count and scan index updates.
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = IW'(idx_ext + CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.val_load) begin
      value_r <= in_value;
    end
  end

  // Result register; it holds until the transaction is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_element_r <= cmd.out_elem ? rd_data : 32'd0;
      out_status_r  <= cmd.out_status;
      out_count_r   <= 5'(count_nxt);
      out_last_r    <= cmd.out_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_element = out_element_r;
  assign out_status  = out_status_r;
  assign out_count   = out_count_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

/* rtl/olad_ctrl.sv */
// Controller of the ordered list: sequences append, search, compaction and
// read-out, and issues commands to the datapath.
// Depends on olad_pkg.
`default_nettype none

module olad_ctrl
  import olad_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire dp_stat_t   stat,
  output dp_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RESULT = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] status_r, status_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.rd_sel = RD_IDX;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_RESULT;
          status_nxt = ST_OK;
          unique case (in_cmd)
            CMD_APPEND: begin
              if (stat.full) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.we_append = 1'b1;
                cmd.cnt_inc   = 1'b1;
              end
            end
            CMD_DELETE: begin
              if (stat.empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                cmd.val_load = 1'b1;
                cmd.idx_clr  = 1'b1;
                cmd.rd_sel   = RD_ZERO;
                state_nxt    = S_SEARCH;
              end
            end
            CMD_READ: begin
              if (stat.empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                cmd.idx_clr = 1'b1;
                cmd.rd_sel  = RD_ZERO;
                state_nxt   = S_READ;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SEARCH: begin
        // Compare the entry at the index; the next one is already being read.
        cmd.rd_sel = RD_IDX1;
        if (stat.match) begin
          if (stat.at_end) begin
            cmd.cnt_dec = 1'b1;
            status_nxt  = ST_OK;
            state_nxt   = S_RESULT;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else if (stat.at_end) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        // Move the following entry down by one place.
        cmd.we_shift = 1'b1;
        cmd.rd_sel   = RD_IDX2;
        if (stat.shift_end) begin
          cmd.cnt_dec = 1'b1;
          status_nxt  = ST_OK;
          state_nxt   = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_READ: begin
        // Emit one entry per free result slot; re-read while stalled.
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_elem   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_last   = stat.at_end;
          if (stat.at_end) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.rd_sel  = RD_IDX1;
          end
        end else begin
          cmd.rd_sel = RD_IDX;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = status_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire
